// File: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held
`define HBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same check, without the reset disable
`define HBC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hbc_pkg.sv
// Package with shared types and codes of the histogram bin counter
`timescale 1ns / 1ps

package hbc_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned BWIDTH_W = 63;
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 2;
    localparam int unsigned OUT_BIN_W = 8;
    localparam int unsigned OUT_CNT_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_SPARE  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_SAT   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_LOW   = 2'd0,
        REG_HIGH  = 2'd1,
        REG_WIDTH = 2'd2,
        REG_NONE  = 2'd3
    } reg_index_t;

endpackage

// File: rtl/hbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps

module hbc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hbc_div.sv
// Bounded restoring divider: one quotient bit per cycle, result saturated
`timescale 1ns / 1ps

module hbc_div #(
    parameter int unsigned MAX_BINS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hbc_pkg::VALUE_W-1:0]   dividend,
    input  logic [hbc_pkg::BWIDTH_W-1:0]  divisor,
    output logic                          done,
    output logic [$clog2(MAX_BINS)-1:0]   quotient
);

    localparam int unsigned IDX_W  = $clog2(MAX_BINS);
    localparam int unsigned QW     = IDX_W + 1;
    localparam int unsigned CMP_W  = hbc_pkg::BWIDTH_W + IDX_W;
    localparam int unsigned STEP_W = $clog2(QW + 1);

    logic [hbc_pkg::VALUE_W-1:0] rem_reg, rem_next;
    logic [CMP_W-1:0]            dvs_reg, dvs_next;
    logic [QW-1:0]               quo_reg, quo_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [hbc_pkg::BWIDTH_W-1:0] w_eff;
    logic                        fits;

    // zero width acts as one
    assign w_eff = (divisor == '0) ? hbc_pkg::BWIDTH_W'(1) : divisor;
    assign fits  = (CMP_W'(rem_reg) >= dvs_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dvs_next  = {w_eff, IDX_W'(0)};
            quo_next  = '0;
            step_next = STEP_W'(IDX_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - hbc_pkg::VALUE_W'(dvs_reg);
            end
            quo_next = {quo_reg[QW-2:0], fits};
            dvs_next = dvs_reg >> 1;
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = (quo_reg > QW'(MAX_BINS - 1)) ? IDX_W'(MAX_BINS - 1)
                                                    : quo_reg[IDX_W-1:0];

endmodule

// File: rtl/histogram_bin_counter_core.sv
// Top level: histogram bin counter with bin counts held in a RAM
//
// channel | direction | handshake        | payload
// config  | in        | wr_en            | wr_index, wr_data
// request | in        | start & !busy    | func, value
// result  | out       | done (one cycle) | bin_index, bin_count, total_count, status
//
// A request passes through S_CLAMP, S_CHECK, S_DIV and S_UPD from accept to done;
// the bit-serial divider sets most of that time. A value below range finishes in S_CHECK.
// After reset the bin RAM is cleared one entry a cycle, all MAX_BINS entries,
// with busy high; config writes are taken meanwhile.
// Results cannot be stalled; done pulses once per request.
`timescale 1ns / 1ps

module histogram_bin_counter_core #(
    parameter int unsigned MAX_BINS    = 256,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [hbc_pkg::INDEX_W-1:0]       wr_index,
    input  logic [hbc_pkg::VALUE_W-1:0]       wr_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [hbc_pkg::FUNC_W-1:0]        func,
    input  logic signed [hbc_pkg::VALUE_W-1:0] value,
    output logic                              done,
    output logic [hbc_pkg::OUT_BIN_W-1:0]     bin_index,
    output logic [hbc_pkg::OUT_CNT_W-1:0]     bin_count,
    output logic [hbc_pkg::OUT_CNT_W-1:0]     total_count,
    output logic [hbc_pkg::STATUS_W-1:0]      status
);

    localparam int unsigned IDX_W = $clog2(MAX_BINS);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CLAMP = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_UPD   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [hbc_pkg::VALUE_W-1:0] low_reg, low_next;
    logic signed [hbc_pkg::VALUE_W-1:0] high_reg, high_next;
    logic [hbc_pkg::BWIDTH_W-1:0]       width_reg, width_next;

    logic [hbc_pkg::FUNC_W-1:0]         func_reg, func_next;
    logic signed [hbc_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [hbc_pkg::VALUE_W-1:0]        diff_reg, diff_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [IDX_W-1:0]                   clr_reg, clr_next;
    logic [COUNT_WIDTH-1:0]             total_reg, total_next;

    logic                               done_reg, done_next;
    logic [hbc_pkg::OUT_BIN_W-1:0]      bin_reg, bin_next;
    logic [hbc_pkg::OUT_CNT_W-1:0]      cnt_out_reg, cnt_out_next;
    logic [hbc_pkg::OUT_CNT_W-1:0]      tot_out_reg, tot_out_next;
    hbc_pkg::status_t                   st_reg, st_next;

    logic                               div_start, div_done;
    logic [IDX_W-1:0]                   div_q;
    logic                               div_busy_seen_reg;
    logic                               ram_we;
    logic [IDX_W-1:0]                   ram_waddr;
    logic [COUNT_WIDTH-1:0]             ram_wdata, ram_rdata;

    hbc_div #(.MAX_BINS(MAX_BINS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (width_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    hbc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BINS)) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (div_q),
        .rdata (ram_rdata)
    );

    // config writes
    always_comb
    begin
        low_next   = low_reg;
        high_next  = high_reg;
        width_next = width_reg;
        if (wr_en)
        begin
            case (hbc_pkg::reg_index_t'(wr_index))
                hbc_pkg::REG_LOW:   low_next   = wr_data;
                hbc_pkg::REG_HIGH:  high_next  = wr_data;
                hbc_pkg::REG_WIDTH: width_next = wr_data[hbc_pkg::BWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        val_next     = val_reg;
        diff_next    = diff_reg;
        idx_next     = idx_reg;
        clr_next     = clr_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        bin_next     = bin_reg;
        cnt_out_next = cnt_out_reg;
        tot_out_next = tot_out_reg;
        st_next      = st_reg;
        div_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = ram_rdata;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(MAX_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    val_next   = value;
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                if (high_reg < val_reg)
                begin
                    val_next = high_reg;
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (val_reg < low_reg)
                begin
                    done_next    = 1'b1;
                    bin_next     = '0;
                    cnt_out_next = '0;
                    tot_out_next = hbc_pkg::OUT_CNT_W'(total_reg);
                    st_next      = hbc_pkg::ST_BELOW;
                    state_next   = S_IDLE;
                end
                else
                begin
                    diff_next  = val_reg - low_reg;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = div_q;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                st_next = hbc_pkg::ST_OK;
                case (hbc_pkg::func_t'(func_reg))
                    hbc_pkg::FUNC_ADD:
                    begin
                        if (ram_rdata == CNT_MAX || total_reg == CNT_MAX)
                        begin
                            st_next = hbc_pkg::ST_SAT;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = ram_rdata + COUNT_WIDTH'(1);
                            total_next = total_reg + COUNT_WIDTH'(1);
                        end
                    end
                    hbc_pkg::FUNC_REMOVE:
                    begin
                        if (ram_rdata == '0 || total_reg == '0)
                        begin
                            st_next = hbc_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = ram_rdata - COUNT_WIDTH'(1);
                            total_next = total_reg - COUNT_WIDTH'(1);
                        end
                    end
                    default: ;
                endcase
                done_next    = 1'b1;
                bin_next     = hbc_pkg::OUT_BIN_W'(idx_reg);
                cnt_out_next = hbc_pkg::OUT_CNT_W'(ram_wdata);
                tot_out_next = hbc_pkg::OUT_CNT_W'(total_next);
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // kick the divider on the first cycle in S_DIV, once diff_reg holds the difference
        if (state_reg == S_DIV && state_next == S_DIV && !div_busy_seen_reg)
        begin
            div_start = 1'b1;
        end
    end

    // divider start is issued once, on the first cycle in S_DIV
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_seen_reg <= 1'b0;
        end
        else
        begin
            div_busy_seen_reg <= (state_reg == S_DIV) && (state_next == S_DIV);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
            low_reg   <= '0;
            high_reg  <= hbc_pkg::VALUE_W'(255);
            width_reg <= hbc_pkg::BWIDTH_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            width_reg <= width_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        val_reg     <= val_next;
        diff_reg    <= diff_next;
        idx_reg     <= idx_next;
        bin_reg     <= bin_next;
        cnt_out_reg <= cnt_out_next;
        tot_out_reg <= tot_out_next;
        st_reg      <= st_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign bin_index   = bin_reg;
    assign bin_count   = cnt_out_reg;
    assign total_count = tot_out_reg;
    assign status      = st_reg;

endmodule

// File: rtl/hbc_checker.sv
// Port-level checker for the histogram bin counter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hbc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [hbc_pkg::OUT_BIN_W-1:0]     bin_index,
    input logic [hbc_pkg::OUT_CNT_W-1:0]     bin_count,
    input logic [hbc_pkg::STATUS_W-1:0]      status
);

    // a result only shows once the engine is free again
    `HBC_ASSERT(a_done_idle, clk, rst_n, done |-> !busy, "done while busy")
    // an accepted request occupies the engine on the next cycle
    `HBC_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept not taken")
    // one pulse per result
    `HBC_ASSERT(a_done_pulse, clk, rst_n, done |=> !done, "done longer than one cycle")
    // below-range results report bin zero and count zero
    `HBC_ASSERT(a_below_zero, clk, rst_n,
        (done && status == hbc_pkg::ST_BELOW) |-> (bin_index == '0 && bin_count == '0),
        "below-range result with nonzero bin")

endmodule

bind histogram_bin_counter_core hbc_checker u_hbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .bin_index (bin_index),
    .bin_count (bin_count),
    .status    (status)
);

// File: verif/tb.sv
// Self-checking testbench for the histogram bin counter core
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [hbc_pkg::OUT_BIN_W-1:0] bin_index;
        logic [hbc_pkg::OUT_CNT_W-1:0] bin_count;
        logic [hbc_pkg::OUT_CNT_W-1:0] total_count;
        hbc_pkg::status_t              status;
    } bin_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          wr_en;
    logic [hbc_pkg::INDEX_W-1:0]   wr_index;
    logic [hbc_pkg::VALUE_W-1:0]   wr_data;
    logic                          start;
    logic                          busy;
    logic [hbc_pkg::FUNC_W-1:0]    func;
    logic signed [hbc_pkg::VALUE_W-1:0] value;
    logic                          done;
    logic [hbc_pkg::OUT_BIN_W-1:0] bin_index;
    logic [hbc_pkg::OUT_CNT_W-1:0] bin_count;
    logic [hbc_pkg::OUT_CNT_W-1:0] total_count;
    logic [hbc_pkg::STATUS_W-1:0]  status;

    // predictor state
    logic [63:0] lo_reg, hi_reg, width_reg;
    logic [31:0] bin_tally [256];
    logic [31:0] held_total;
    bin_result_t pending_results [$];
    int          errors;
    int          requests_sent;
    int          results_seen;

    histogram_bin_counter_core dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .start(start), .busy(busy), .func(func),
        .value(value), .done(done), .bin_index(bin_index),
        .bin_count(bin_count), .total_count(total_count), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("tb: errors");
        $finish;
    end

    function automatic bin_result_t bin_request(logic [1:0] op, logic [63:0] v);
        bin_result_t r;
        logic [63:0] w;
        logic [63:0] q;
        int          idx;
        w = (width_reg == 0) ? 64'd1 : width_reg;
        if ($signed(hi_reg) < $signed(v))
            v = hi_reg;
        if ($signed(v) < $signed(lo_reg))
        begin
            r.bin_index = '0;
            r.bin_count = '0;
            r.total_count = held_total;
            r.status = hbc_pkg::ST_BELOW;
            return r;
        end
        q = (v - lo_reg) / w;
        if (q > 255)
            q = 255;
        idx = int'(q);
        r.status = hbc_pkg::ST_OK;
        if (op == hbc_pkg::FUNC_ADD)
        begin
            if (bin_tally[idx] == 32'hFFFF_FFFF || held_total == 32'hFFFF_FFFF)
                r.status = hbc_pkg::ST_SAT;
            else
            begin
                bin_tally[idx]++;
                held_total++;
            end
        end
        else if (op == hbc_pkg::FUNC_REMOVE)
        begin
            if (bin_tally[idx] == 0 || held_total == 0)
                r.status = hbc_pkg::ST_EMPTY;
            else
            begin
                bin_tally[idx]--;
                held_total--;
            end
        end
        r.bin_index = q[7:0];
        r.bin_count = bin_tally[idx];
        r.total_count = held_total;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        bin_result_t exp_r;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h %h %h %h", $time,
                         bin_index, bin_count, total_count, status);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (bin_index !== exp_r.bin_index)
                begin
                    $display("%0t: bin_index expected %0d actual %0d", $time,
                             exp_r.bin_index, bin_index);
                    errors++;
                end
                if (bin_count !== exp_r.bin_count)
                begin
                    $display("%0t: bin_count expected %0d actual %0d", $time,
                             exp_r.bin_count, bin_count);
                    errors++;
                end
                if (total_count !== exp_r.total_count)
                begin
                    $display("%0t: total_count expected %0d actual %0d", $time,
                             exp_r.total_count, total_count);
                    errors++;
                end
                if (status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, status);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(hbc_pkg::reg_index_t idx, logic [63:0] data);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = data;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == hbc_pkg::REG_LOW)
            lo_reg = data;
        else if (idx == hbc_pkg::REG_HIGH)
            hi_reg = data;
        else if (idx == hbc_pkg::REG_WIDTH)
            width_reg = {1'b0, data[62:0]};
    endtask

    // drive one request; start stays high unless keep_going is clear
    task automatic send_request(logic [1:0] op, logic [63:0] v, bit keep_going);
        start = 1'b1;
        func = op;
        value = v;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results.push_back(bin_request(op, v));
        requests_sent++;
        @(negedge clk);
        if (!keep_going)
            start = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_config(logic [63:0] lo, logic [63:0] hi, logic [63:0] w);
        wait_idle();
        write_reg(hbc_pkg::REG_LOW, lo);
        write_reg(hbc_pkg::REG_HIGH, hi);
        write_reg(hbc_pkg::REG_WIDTH, w);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] w;
        int          sel;
        w = (width_reg == 0) ? 64'd1 : width_reg;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return lo_reg + $urandom_range(0, 40) * w + ({$urandom, $urandom} % w);
        else if (sel < 85)
            return hi_reg + $urandom_range(0, 3);
        else if (sel < 92)
            return lo_reg - $urandom_range(1, 3);
        else
            return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int n);
        int          burst;
        logic [1:0]  op;
        int          sel;
        while (n > 0)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && n > 0; i++)
            begin
                sel = $urandom_range(0, 99);
                op = (sel < 50) ? hbc_pkg::FUNC_ADD : (sel < 80) ? hbc_pkg::FUNC_REMOVE :
                     (sel < 95) ? hbc_pkg::FUNC_QUERY : hbc_pkg::FUNC_SPARE;
                send_request(op, pick_value(), (i < burst - 1) && (n > 1));
                n--;
            end
            repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    endtask

    task automatic test_directed();
        send_request(hbc_pkg::FUNC_QUERY, 64'd0, 1'b0);
        send_request(hbc_pkg::FUNC_REMOVE, 64'd5, 1'b0);                 // empty bin
        send_request(hbc_pkg::FUNC_ADD, 64'd0, 1'b1);
        send_request(hbc_pkg::FUNC_ADD, 64'd0, 1'b1);
        send_request(hbc_pkg::FUNC_ADD, 64'd255, 1'b1);
        send_request(hbc_pkg::FUNC_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);  // clamps to top
        send_request(hbc_pkg::FUNC_ADD, 64'h8000_0000_0000_0000, 1'b1);  // below range
        send_request(hbc_pkg::FUNC_REMOVE, -64'sd1, 1'b1);
        send_request(hbc_pkg::FUNC_REMOVE, 64'd0, 1'b1);
        send_request(hbc_pkg::FUNC_SPARE, 64'd255, 1'b1);
        send_request(hbc_pkg::FUNC_REMOVE, 64'd255, 1'b1);
        send_request(hbc_pkg::FUNC_REMOVE, 64'd255, 1'b1);
        send_request(hbc_pkg::FUNC_REMOVE, 64'd255, 1'b0);
        // full signed range, widest bins
        set_config(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'h7FFF_FFFF_FFFF_FFFF);
        send_request(hbc_pkg::FUNC_ADD, 64'h8000_0000_0000_0000, 1'b1);
        send_request(hbc_pkg::FUNC_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(hbc_pkg::FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(hbc_pkg::FUNC_QUERY, 64'h5555_5555_AAAA_AAAA, 1'b0);
        // zero width acts as one, quotient saturates
        set_config(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        send_request(hbc_pkg::FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
        send_request(hbc_pkg::FUNC_ADD, 64'h8000_0000_0000_0003, 1'b0);
        // high below low: everything below range
        set_config(64'd100, -64'sd100, 64'd7);
        send_request(hbc_pkg::FUNC_ADD, 64'd150, 1'b1);
        send_request(hbc_pkg::FUNC_QUERY, 64'd100, 1'b0);
        wait_idle();
        write_reg(hbc_pkg::REG_NONE, {64{1'b1}});
    endtask

    task automatic test_random();
        set_config(64'd0, 64'd255, 64'd1);
        random_phase(400);
        set_config(-64'sd1000, 64'd1000, 64'd9);
        random_phase(400);
        set_config(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'h0100_0000_0000_0000);
        random_phase(300);
        set_config(64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_FFFF, 64'd0);
        random_phase(300);
        set_config(-64'sd50, -64'sd10, 64'h7FFF_FFFF_FFFF_FFFF);
        random_phase(300);
    endtask

    initial
    begin
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = hbc_pkg::REG_LOW;
        wr_data = '0;
        start = 1'b0;
        func = hbc_pkg::FUNC_ADD;
        value = '0;
        lo_reg = 64'd0;
        hi_reg = 64'd255;
        width_reg = 64'd1;
        held_total = '0;
        for (int i = 0; i < 256; i++)
            bin_tally[i] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();
        wait_idle();
        if (pending_results.size() != 0)
            errors++;
        $display("run: %0d requests, %0d results over directed and random bin layouts",
                 requests_sent, results_seen);
        $display("run: add/remove/query, clamping, below range and empty bins, %0d errors",
                 errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: histogram_bin_counter_core.f
+incdir+rtl
rtl/hbc_pkg.sv
rtl/hbc_ram.sv
rtl/hbc_div.sv
rtl/histogram_bin_counter_core.sv
rtl/hbc_checker.sv
verif/tb.sv
